[sv/slfr_pkg.sv]
// Shared types and constants for the subtractive lagged-Fibonacci generator.
// No dependencies; imported by the core, the checker and the testbench.
package slfr_pkg;

    localparam int VALUE_W = 30;
    localparam int SEED_W  = 28;
    localparam int PTR_W   = 6;

    localparam int TABLE_LEN   = 55;
    localparam int LAG_START   = 31;
    localparam int MIX_OFFSET  = 30;
    localparam int MIX_PASSES  = 4;
    localparam int SCATTER     = 21;
    localparam int PASS_W      = 2;

    localparam logic [VALUE_W-1:0] MODULUS   = 30'd1000000000;
    localparam logic [SEED_W-1:0]  SEED_BASE = 28'd161803398;
    localparam logic [SEED_W-1:0]  DEFAULT_SEED_RESET = 28'd1;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL_FIRST,
        ST_FILL,
        ST_MIX_RDA,
        ST_MIX_RDB,
        ST_MIX_WR,
        ST_DRAW_RDA,
        ST_DRAW_RDB,
        ST_DRAW_WR
    } slfr_state_t;

    // Step a table position through 1..55; anything at or above 55 wraps to 1.
    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p >= PTR_W'(TABLE_LEN)) begin
            r = PTR_W'(1);
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

[sv/slfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the lag table of the generator core.
module slfr_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 55
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/subtractive_lagged_fibonacci_rng_core.sv]
// Subtractive lagged-Fibonacci generator core (modulo 10^9, 55 entries, lag 31).
// Depends on slfr_pkg and slfr_ram (the lag table).
//
// A draw (cmd 0) returns the next value in [0, 999999999]; divide by 10^9 for a
// uniform real in [0,1). A reseed (cmd 1) rebuilds the table from seed, mixes it
// and discards one draw; it returns no result. A draw before any reseed first
// seeds from default_seed. Seeds above 161803398 saturate. All table work goes
// through one subtract-and-wrap unit and the single read port of the table RAM,
// in read-read-write steps: a draw shows its result when its step ends (held while
// an earlier result is unaccepted), and the block is ready again in that same
// cycle; a reseed (or the first draw) runs 55 fill writes, then 220 mixing steps,
// then the draw. s_ready is low while an item is being worked on.
module subtractive_lagged_fibonacci_rng_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [slfr_pkg::SEED_W-1:0]  cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    input  logic [slfr_pkg::SEED_W-1:0]  s_seed,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [slfr_pkg::VALUE_W-1:0] m_random_value
);
    import slfr_pkg::*;

    slfr_state_t         state_reg, state_next;
    logic [SEED_W-1:0]   default_seed_reg;
    logic [PTR_W-1:0]    lead_reg, lead_next;
    logic [PTR_W-1:0]    lag_reg, lag_next;
    logic                seeded_reg, seeded_next;
    logic                emit_reg, emit_next;
    logic [VALUE_W-1:0]  cur_reg, cur_next;
    logic [VALUE_W-1:0]  prev_reg, prev_next;
    logic [VALUE_W-1:0]  opa_reg, opa_next;
    logic [PTR_W-1:0]    pos_reg, pos_next;
    logic [PTR_W-1:0]    step_reg, step_next;
    logic [PTR_W-1:0]    mix_i_reg, mix_i_next;
    logic [PTR_W-1:0]    mix_j_reg, mix_j_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;

    logic                ram_wr_en;
    logic [PTR_W-1:0]    ram_wr_addr;
    logic [VALUE_W-1:0]  ram_wr_data;
    logic [PTR_W-1:0]    ram_rd_addr;
    logic [VALUE_W-1:0]  ram_rd_data;

    logic                in_xfer;
    logic [SEED_W-1:0]   seed_src;
    logic [SEED_W-1:0]   seed_sat;
    logic [VALUE_W-1:0]  seed_start;
    logic [VALUE_W-1:0]  sub_a, sub_b, sub_res;
    logic [VALUE_W:0]    sub_diff;
    logic [PTR_W:0]      pos_sum;
    logic                out_free;

    slfr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_LEN)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign in_xfer        = s_valid && s_ready;
    assign m_valid        = out_valid_reg;
    assign m_random_value = out_value_reg;
    assign out_free       = !out_valid_reg || m_ready;

    // Seed saturation and starting value
    always_comb begin
        seed_src   = (s_cmd == CMD_RESEED) ? s_seed : default_seed_reg;
        seed_sat   = (seed_src > SEED_BASE) ? SEED_BASE : seed_src;
        seed_start = VALUE_W'(SEED_BASE - seed_sat);
    end

    // Shared subtract-and-wrap unit
    always_comb begin
        if (state_reg == ST_FILL) begin
            sub_a = cur_reg;
            sub_b = prev_reg;
        end else begin
            sub_a = opa_reg;
            sub_b = ram_rd_data;
        end
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        if (sub_diff[VALUE_W]) begin
            sub_res = VALUE_W'(sub_diff + {1'b0, MODULUS});
        end else begin
            sub_res = sub_diff[VALUE_W-1:0];
        end
    end

    assign pos_sum = {1'b0, pos_reg} + (PTR_W+1)'(SCATTER);

    always_comb begin
        state_next     = state_reg;
        lead_next      = lead_reg;
        lag_next       = lag_reg;
        seeded_next    = seeded_reg;
        emit_next      = emit_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        opa_next       = opa_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        mix_i_next     = mix_i_reg;
        mix_j_next     = mix_j_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_value_next = out_value_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = mix_i_reg - PTR_W'(1);
        ram_wr_data    = sub_res;
        ram_rd_addr    = mix_j_reg - PTR_W'(1);

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    cur_next = seed_start;
                    if (s_cmd == CMD_RESEED) begin
                        emit_next  = 1'b0;
                        state_next = ST_FILL_FIRST;
                    end else if (seeded_reg) begin
                        emit_next  = 1'b1;
                        state_next = ST_DRAW_RDA;
                    end else begin
                        emit_next  = 1'b1;
                        state_next = ST_FILL_FIRST;
                    end
                end
            end
            ST_FILL_FIRST: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = PTR_W'(TABLE_LEN - 1);
                ram_wr_data = cur_reg;
                prev_next   = VALUE_W'(1);
                pos_next    = PTR_W'(SCATTER);
                step_next   = PTR_W'(1);
                state_next  = ST_FILL;
            end
            ST_FILL: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg - PTR_W'(1);
                ram_wr_data = prev_reg;
                prev_next   = sub_res;
                cur_next    = prev_reg;
                if (pos_sum >= (PTR_W+1)'(TABLE_LEN)) begin
                    pos_next = PTR_W'(pos_sum - (PTR_W+1)'(TABLE_LEN));
                end else begin
                    pos_next = pos_sum[PTR_W-1:0];
                end
                step_next = step_reg + PTR_W'(1);
                if (step_reg == PTR_W'(TABLE_LEN - 1)) begin
                    mix_i_next = PTR_W'(1);
                    mix_j_next = PTR_W'(MIX_OFFSET + 2);
                    pass_next  = '0;
                    state_next = ST_MIX_RDA;
                end
            end
            ST_MIX_RDA: begin
                ram_rd_addr = mix_i_reg - PTR_W'(1);
                state_next  = ST_MIX_RDB;
            end
            ST_MIX_RDB: begin
                opa_next   = ram_rd_data;
                state_next = ST_MIX_WR;
            end
            ST_MIX_WR: begin
                ram_wr_en  = 1'b1;
                mix_i_next = ptr_advance(mix_i_reg);
                mix_j_next = ptr_advance(mix_j_reg);
                state_next = ST_MIX_RDA;
                if (mix_i_reg == PTR_W'(TABLE_LEN)) begin
                    pass_next = pass_reg + PASS_W'(1);
                    if (pass_reg == PASS_W'(MIX_PASSES - 1)) begin
                        lead_next   = '0;
                        lag_next    = PTR_W'(LAG_START);
                        seeded_next = 1'b1;
                        state_next  = ST_DRAW_RDA;
                    end
                end
            end
            ST_DRAW_RDA: begin
                lead_next   = ptr_advance(lead_reg);
                lag_next    = ptr_advance(lag_reg);
                ram_rd_addr = ptr_advance(lead_reg) - PTR_W'(1);
                state_next  = ST_DRAW_RDB;
            end
            ST_DRAW_RDB: begin
                opa_next    = ram_rd_data;
                ram_rd_addr = lag_reg - PTR_W'(1);
                state_next  = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                ram_rd_addr = lag_reg - PTR_W'(1);
                ram_wr_addr = lead_reg - PTR_W'(1);
                if (!emit_reg) begin
                    ram_wr_en  = 1'b1;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    ram_wr_en      = 1'b1;
                    out_valid_next = 1'b1;
                    out_value_next = sub_res;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_seed_reg <= DEFAULT_SEED_RESET;
            lead_reg         <= '0;
            lag_reg          <= PTR_W'(LAG_START);
            seeded_reg       <= 1'b0;
            emit_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            pos_reg          <= '0;
            step_reg         <= '0;
            mix_i_reg        <= '0;
            mix_j_reg        <= '0;
            pass_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                default_seed_reg <= cfg_wr_data;
            end
            lead_reg      <= lead_next;
            lag_reg       <= lag_next;
            seeded_reg    <= seeded_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            step_reg      <= step_next;
            mix_i_reg     <= mix_i_next;
            mix_j_reg     <= mix_j_next;
            pass_reg      <= pass_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        opa_reg       <= opa_next;
        out_value_reg <= out_value_next;
    end

endmodule

[sv/slfr_checker.sv]
// Port-level checks for the generator core, attached to it by bind.
// Depends on slfr_pkg.
module slfr_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         s_cmd,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [slfr_pkg::VALUE_W-1:0] m_random_value
);
    import slfr_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_value))
        else $error("result changed or dropped while stalled");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_random_value < MODULUS)
        else $error("result outside modulus range");

    // the core is busy in the cycle after it takes an item
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared one cycle after transfer");

    a_reseed_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == CMD_RESEED |-> ##2 !$rose(m_valid))
        else $error("reseed produced a result too early");

endmodule

bind subtractive_lagged_fibonacci_rng_core slfr_checker u_slfr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_cmd          (s_cmd),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_random_value (m_random_value)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for subtractive_lagged_fibonacci_rng_core: a scoreboard class
// predicts every drawn value from its own copy of the lag table. Depends on slfr_pkg.
module testbench;
    import slfr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 800;
    localparam int          PHASE_ITEMS   = 450;
    localparam int          PHASE_COUNT   = 4;
    localparam int          MAX_STALL     = 32;
    localparam logic [SEED_W-1:0] SEED_ALL_ONES = '1;

    class rng_scoreboard;
        logic [VALUE_W-1:0] lag_table [1:TABLE_LEN];
        logic [PTR_W-1:0]   lead_ptr;
        logic [PTR_W-1:0]   lag_ptr;
        bit                 seeded;
        logic [SEED_W-1:0]  default_seed;
        logic [VALUE_W-1:0] pending_values [$];
        int                 errors;
        int                 draws;
        int                 reseeds;
        int                 compared;

        function new();
            foreach (lag_table[i]) lag_table[i] = '0;
            lead_ptr     = '0;
            lag_ptr      = PTR_W'(LAG_START);
            seeded       = 1'b0;
            default_seed = DEFAULT_SEED_RESET;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) begin
                $display("MISMATCH: %s", msg);
            end
        endfunction

        function logic [VALUE_W-1:0] sub_wrap(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
            if (a >= b) begin
                return a - b;
            end
            return a + (MODULUS - b);
        endfunction

        function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
            return (p >= PTR_W'(TABLE_LEN)) ? PTR_W'(1) : p + PTR_W'(1);
        endfunction

        function void fill(logic [SEED_W-1:0] seed);
            logic [SEED_W-1:0]  sat;
            logic [VALUE_W-1:0] cur;
            logic [VALUE_W-1:0] prev;
            int                 pos;
            sat = (seed > SEED_BASE) ? SEED_BASE : seed;
            cur = VALUE_W'(SEED_BASE - sat);
            lag_table[TABLE_LEN] = cur;
            prev = VALUE_W'(1);
            for (int i = 1; i < TABLE_LEN; i++) begin
                pos = (SCATTER * i) % TABLE_LEN;
                lag_table[pos] = prev;
                prev = sub_wrap(cur, prev);
                cur = lag_table[pos];
            end
            for (int k = 0; k < MIX_PASSES; k++) begin
                for (int i = 1; i <= TABLE_LEN; i++) begin
                    lag_table[i] = sub_wrap(lag_table[i],
                                            lag_table[1 + (i + MIX_OFFSET) % TABLE_LEN]);
                end
            end
            lead_ptr = '0;
            lag_ptr  = PTR_W'(LAG_START);
            seeded   = 1'b1;
        endfunction

        function logic [VALUE_W-1:0] draw_next();
            lead_ptr = step_ptr(lead_ptr);
            lag_ptr  = step_ptr(lag_ptr);
            lag_table[lead_ptr] = sub_wrap(lag_table[lead_ptr], lag_table[lag_ptr]);
            return lag_table[lead_ptr];
        endfunction

        function void note_transfer(logic cmd, logic [SEED_W-1:0] seed);
            if (cmd == CMD_RESEED) begin
                fill(seed);
                void'(draw_next());
                reseeds++;
            end else begin
                if (!seeded) begin
                    fill(default_seed);
                end
                pending_values.push_back(draw_next());
                draws++;
            end
        endfunction

        function void check_value(logic [VALUE_W-1:0] got);
            logic [VALUE_W-1:0] want;
            if (pending_values.size() == 0) begin
                flag($sformatf("random_value %0d with no draw outstanding", got));
                return;
            end
            want = pending_values.pop_front();
            compared++;
            if (got !== want) begin
                flag($sformatf("random_value expected %0d, got %0d", want, got));
            end
        endfunction
    endclass

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                cfg_wr_en      = 1'b0;
    logic [SEED_W-1:0]   cfg_wr_data    = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_cmd          = CMD_DRAW;
    logic [SEED_W-1:0]   s_seed         = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [VALUE_W-1:0]  m_random_value;

    rng_scoreboard sb = new();
    int unsigned   cycles     = 0;
    int            stall_pct  = 0;
    int            stall_run  = 0;
    int            gap_max    = 0;

    subtractive_lagged_fibonacci_rng_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_seed         (s_seed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_value (m_random_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stall runs at a per-phase rate
    always @(negedge aclk) begin
        if (stall_run > 0) begin
            m_ready <= 1'b0;
            stall_run--;
        end else if (stall_pct == 0 || $urandom_range(0, 99) >= stall_pct) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            stall_run = $urandom_range(0, MAX_STALL - 1);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_value(m_random_value);
        end
    end

    task automatic send_item(logic cmd, logic [SEED_W-1:0] seed);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_seed  <= seed;
        do @(posedge aclk); while (!s_ready);
        sb.note_transfer(cmd, seed);
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            s_cmd   <= 1'($urandom);
            s_seed  <= SEED_W'($urandom);
        end
    endtask

    task automatic write_default_seed(logic [SEED_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sb.default_seed = value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Wait for outstanding draws, then let any trailing reseed finish
    task automatic settle();
        while (sb.pending_values.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [SEED_W-1:0] phase_seeds [PHASE_COUNT];
        logic [SEED_W-1:0] seed;
        logic              cmd;
        int                burst_left;
        int                reseeds_left;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        case ($urandom_range(0, 3))
            0: write_default_seed('0);
            1: write_default_seed(SEED_BASE);
            2: write_default_seed(SEED_ALL_ONES);
            default: write_default_seed(SEED_W'($urandom));
        endcase

        // Directed: draw before seed, seed extremes, saturation, back-to-back reseeds
        send_item(CMD_DRAW, SEED_ALL_ONES);
        send_item(CMD_DRAW, '0);
        send_item(CMD_RESEED, '0);
        repeat (3) send_item(CMD_DRAW, '0);
        send_item(CMD_RESEED, SEED_BASE);
        repeat (2) send_item(CMD_DRAW, SEED_ALL_ONES);
        send_item(CMD_RESEED, SEED_ALL_ONES);
        repeat (2) send_item(CMD_DRAW, '0);
        send_item(CMD_RESEED, SEED_BASE + 1'b1);
        send_item(CMD_DRAW, '0);
        send_item(CMD_RESEED, 28'h5555555);
        send_item(CMD_RESEED, 28'hAAAAAAA);
        repeat (2) send_item(CMD_DRAW, '0);
        send_item(CMD_RESEED, SEED_W'($urandom_range(0, SEED_BASE)));
        send_item(CMD_DRAW, '0);
        idle_cycles(1);
        settle();

        phase_seeds[0] = '0;
        phase_seeds[1] = SEED_BASE;
        phase_seeds[2] = SEED_ALL_ONES;
        phase_seeds[3] = SEED_W'($urandom);
        reseeds_left = 120;

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            write_default_seed(phase_seeds[ph]);
            stall_pct  = (ph == 0) ? 0 : $urandom_range(5, 40);
            gap_max    = (ph == 0) ? 0 : $urandom_range(2, 8);
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    idle_cycles((gap_max == 0) ? 0 : $urandom_range(0, gap_max));
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;
                cmd = CMD_DRAW;
                if (reseeds_left > 0 && $urandom_range(0, 19) == 0) begin
                    cmd = CMD_RESEED;
                    reseeds_left--;
                end
                case ($urandom_range(0, 7))
                    0: seed = '0;
                    1: seed = SEED_BASE;
                    2: seed = SEED_W'($urandom);
                    default: seed = SEED_W'($urandom_range(0, SEED_BASE));
                endcase
                send_item(cmd, seed);
            end
            idle_cycles(1);
            settle();
        end

        if (sb.pending_values.size() != 0) begin
            sb.flag($sformatf("%0d draws never answered", sb.pending_values.size()));
        end
        $display("Run covered %0d draws and %0d reseeds over %0d default seed settings;",
                 sb.draws, sb.reseeds, PHASE_COUNT + 1);
        $display("%0d values compared, %0d failures in %0d cycles.",
                 sb.compared, sb.errors, cycles);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

[filelist.f]
sv/slfr_pkg.sv
sv/slfr_ram.sv
sv/subtractive_lagged_fibonacci_rng_core.sv
sv/slfr_checker.sv
tb/testbench.sv
